// File: design/assert_macros.svh
// assertion helpers for the rtl files, included by projectile_drag_integrator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: design/pdi_pkg.sv
// ----------------------------------------------------------------------------
// pdi_pkg
// Types, constants and fixed-point helpers of the drag integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package pdi_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAUNCH_SPEED = 2'd0,
        CFG_DRAG_FACTOR  = 2'd1,
        CFG_GRAVITY      = 2'd2,
        CFG_TIME_STEP    = 2'd3
    } t_cfg_reg;

    localparam logic [30:0] RST_LAUNCH_SPEED = 31'd6553600;
    localparam logic [23:0] RST_DRAG_FACTOR  = 24'd102760;
    localparam logic [21:0] RST_GRAVITY      = 22'd642908;
    localparam logic [23:0] RST_TIME_STEP    = 24'd16777;

    localparam int unsigned CORDIC_STEPS = 20;
    localparam int unsigned ITER_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [24:0] DEG90       = 25'sd5898240;
    localparam logic signed [24:0] DEG180      = 25'sd11796480;

    localparam int unsigned PROD_W = 68;

    function automatic logic signed [24:0] atan_deg(input logic [ITER_W-1:0] i);
        logic signed [24:0] v;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // round half up, then floor shift
    function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] p,
                                                     input int unsigned s);
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (s - 1);
        return (p + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > PROD_W'(64'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -PROD_W'(64'sh80000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/pdi_ifs.sv
// ----------------------------------------------------------------------------
// pdi_ifs
// Request channels of the drag integrator: command, result and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdi_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] angle;
    modport source(output valid, command, angle, input ready);
    modport sink(input valid, command, angle, output ready);
endinterface

interface pdi_out_if;
    logic               valid;
    logic               ready;
    logic [30:0]        elapsed_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               landed;
    modport source(output valid, elapsed_time, pos_x, pos_y, vel_x, vel_y, landed,
                   input ready);
    modport sink(input valid, elapsed_time, pos_x, pos_y, vel_x, vel_y, landed,
                 output ready);
endinterface

interface pdi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pdi_pkg::CFG_IDX_W-1:0]   index;
    logic [pdi_pkg::CFG_DAT_W-1:0]   data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/pdi_isqrt.sv
// ----------------------------------------------------------------------------
// pdi_isqrt
// Floor square root of a 64 bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdi_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy, r_done;
    logic [63:0] r_rem, r_res, r_bit;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_value;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_rem >= w_trial) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

`default_nettype wire

// File: design/projectile_drag_integrator.sv
// ----------------------------------------------------------------------------
// projectile_drag_integrator
// Point projectile under gravity and quadratic drag, forward Euler steps.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests: command 0 launches at the given angle (Q8.8 deg),
//   command 1 advances one time step. i_cfg writes the four registers by
//   index and is always ready; write only while the block is idle.
//   o_out gives one result per step in flight: time, position after the
//   step, velocity at its start, and the landed flag.
// Datapath:
//   a launch runs 20 cordic rotations on one shift/add unit and two
//   products on the shared multiplier. A step runs the bit-serial square
//   root, then its products and sequencing, the products all on the one
//   34x34 multiplier. A step while grounded is dropped.
// Reset: registers take their default values, no flight is in progress.
// Stall: the result waits in an output register; the next request is taken
//   meanwhile, and a step only stalls at its end while that register is full and o_out is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module projectile_drag_integrator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pdi_in_if.sink     i_in,
    pdi_out_if.source  o_out,
    pdi_cfg_if.sink    i_cfg
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ROT, ST_FOLD, ST_LC, ST_LS, ST_LE,
        ST_SQX, ST_SQY, ST_SUM, ST_ROOT, ST_K0, ST_K1,
        ST_AX, ST_AY, ST_VX, ST_VY, ST_SX, ST_PX, ST_SY, ST_PY, ST_FIN
    } t_state;

    localparam int unsigned PW = pdi_pkg::PROD_W;

    t_state r_state;

    logic [30:0] r_speed;
    logic [23:0] r_drag;
    logic [21:0] r_grav;
    logic [23:0] r_dt;

    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic [30:0]        r_time;
    logic               r_grounded;

    logic signed [32:0] r_cx, r_sy;
    logic signed [24:0] r_z;
    logic [pdi_pkg::ITER_W-1:0] r_iter;
    logic               r_neg;

    logic signed [PW-1:0] r_prod;
    logic [63:0]          r_acc;
    logic signed [33:0]   r_k;
    logic signed [31:0]   r_ax, r_ay, r_vx1, r_vy1;
    logic signed [32:0]   r_sum;

    logic               r_ovalid;
    logic [30:0]        r_o_time;
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy;
    logic               r_o_landed;

    logic signed [33:0]   w_ma, w_mb;
    logic signed [PW-1:0] w_r16, w_r24, w_r25, w_r30;
    logic signed [24:0]   w_z0, w_zf;
    logic                 w_neg0;
    logic                 w_in_acc, w_fin_go;
    logic signed [31:0]   w_py_new;
    logic [24:0]          w_tround;
    logic [31:0]          w_tsum;
    logic [30:0]          w_time_new;
    logic signed [32:0]   w_xs, w_ys;
    logic                 w_sqrt_busy, w_sqrt_done;
    logic [31:0]          w_root;

    pdi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SUM),
        .i_value (r_acc + r_prod[63:0]),
        .o_busy  (w_sqrt_busy),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_fin_go    = (r_state == ST_FIN) && (!r_ovalid || o_out.ready);

    assign w_z0   = 25'(i_in.angle) <<< 8;
    assign w_neg0 = (w_z0 > pdi_pkg::DEG90) || (w_z0 < -pdi_pkg::DEG90);
    always_comb begin
        if (w_z0 > pdi_pkg::DEG90) begin
            w_zf = w_z0 - pdi_pkg::DEG180;
        end else if (w_z0 < -pdi_pkg::DEG90) begin
            w_zf = w_z0 + pdi_pkg::DEG180;
        end else begin
            w_zf = w_z0;
        end
    end

    assign w_xs = r_cx >>> r_iter;
    assign w_ys = r_sy >>> r_iter;

    assign w_r16 = pdi_pkg::rnd(r_prod, 16);
    assign w_r24 = pdi_pkg::rnd(r_prod, 24);
    assign w_r25 = pdi_pkg::rnd(r_prod, 25);
    assign w_r30 = pdi_pkg::rnd(r_prod, 30);

    assign w_py_new   = pdi_pkg::sat32(PW'(r_py) + w_r25);
    assign w_tround   = {1'b0, r_dt} + 25'd128;
    assign w_tsum     = {1'b0, r_time} + 32'(w_tround[24:8]);
    assign w_time_new = w_tsum[31] ? 31'h7FFFFFFF : w_tsum[30:0];

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_LC: begin
                w_ma = $signed({3'b000, r_speed});
                w_mb = 34'(r_cx);
            end
            ST_LS: begin
                w_ma = $signed({3'b000, r_speed});
                w_mb = 34'(r_sy);
            end
            ST_SQX: begin
                w_ma = 34'(r_vx);
                w_mb = 34'(r_vx);
            end
            ST_SQY: begin
                w_ma = 34'(r_vy);
                w_mb = 34'(r_vy);
            end
            ST_K0: begin
                w_ma = $signed({2'b00, w_root});
                w_mb = $signed({10'd0, r_drag});
            end
            ST_AX: begin
                w_ma = r_k;
                w_mb = 34'(r_vx);
            end
            ST_AY: begin
                w_ma = r_k;
                w_mb = 34'(r_vy);
            end
            ST_VX: begin
                w_ma = 34'(r_ax);
                w_mb = $signed({10'd0, r_dt});
            end
            ST_VY: begin
                w_ma = 34'(r_ay);
                w_mb = $signed({10'd0, r_dt});
            end
            ST_PX, ST_PY, ST_FIN: begin
                w_ma = 34'(r_sum);
                w_mb = $signed({10'd0, r_dt});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_ma) * PW'(w_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= pdi_pkg::RST_LAUNCH_SPEED;
            r_drag  <= pdi_pkg::RST_DRAG_FACTOR;
            r_grav  <= pdi_pkg::RST_GRAVITY;
            r_dt    <= pdi_pkg::RST_TIME_STEP;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                pdi_pkg::CFG_LAUNCH_SPEED: r_speed <= i_cfg.data[30:0];
                pdi_pkg::CFG_DRAG_FACTOR:  r_drag  <= i_cfg.data[23:0];
                pdi_pkg::CFG_GRAVITY:      r_grav  <= i_cfg.data[21:0];
                pdi_pkg::CFG_TIME_STEP:    r_dt    <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_px       <= '0;
            r_py       <= '0;
            r_vx       <= '0;
            r_vy       <= '0;
            r_time     <= '0;
            r_grounded <= 1'b1;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready && !w_fin_go) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (!i_in.command) begin
                            r_cx   <= pdi_pkg::CORDIC_GAIN;
                            r_sy   <= '0;
                            r_z    <= w_zf;
                            r_neg  <= w_neg0;
                            r_iter <= '0;
                            r_state <= ST_ROT;
                        end else if (!r_grounded) begin
                            r_state <= ST_SQX;
                        end
                    end
                end
                ST_ROT: begin
                    if (r_z >= 0) begin
                        r_cx <= r_cx - w_ys;
                        r_sy <= r_sy + w_xs;
                        r_z  <= r_z - pdi_pkg::atan_deg(r_iter);
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_sy <= r_sy - w_xs;
                        r_z  <= r_z + pdi_pkg::atan_deg(r_iter);
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == pdi_pkg::ITER_W'(pdi_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (r_neg) begin
                        r_cx <= -r_cx;
                        r_sy <= -r_sy;
                    end
                    r_state <= ST_LC;
                end
                ST_LC: r_state <= ST_LS;
                ST_LS: begin
                    r_vx    <= pdi_pkg::sat32(w_r30);
                    r_state <= ST_LE;
                end
                ST_LE: begin
                    r_vy       <= pdi_pkg::sat32(w_r30);
                    r_px       <= '0;
                    r_py       <= '0;
                    r_time     <= '0;
                    r_grounded <= 1'b0;
                    r_state    <= ST_IDLE;
                end
                ST_SQX: r_state <= ST_SQY;
                ST_SQY: begin
                    r_acc   <= r_prod[63:0];
                    r_state <= ST_SUM;
                end
                ST_SUM: r_state <= ST_ROOT;
                ST_ROOT: begin
                    if (w_sqrt_done) begin
                        r_state <= ST_K0;
                    end
                end
                ST_K0: r_state <= ST_K1;
                ST_K1: begin
                    r_k     <= w_r24[33:0];
                    r_state <= ST_AX;
                end
                ST_AX: r_state <= ST_AY;
                ST_AY: begin
                    r_ax    <= pdi_pkg::sat32(-w_r16);
                    r_state <= ST_VX;
                end
                ST_VX: begin
                    r_ay    <= pdi_pkg::sat32(-w_r16 - PW'($signed({1'b0, r_grav})));
                    r_state <= ST_VY;
                end
                ST_VY: begin
                    r_vx1   <= pdi_pkg::sat32(PW'(r_vx) + w_r24);
                    r_state <= ST_SX;
                end
                ST_SX: begin
                    r_vy1   <= pdi_pkg::sat32(PW'(r_vy) + w_r24);
                    r_sum   <= 33'(r_vx) + 33'(r_vx1);
                    r_state <= ST_PX;
                end
                ST_PX: r_state <= ST_SY;
                ST_SY: begin
                    r_px    <= pdi_pkg::sat32(PW'(r_px) + w_r25);
                    r_sum   <= 33'(r_vy) + 33'(r_vy1);
                    r_state <= ST_PY;
                end
                ST_PY: r_state <= ST_FIN;
                ST_FIN: begin
                    if (w_fin_go) begin
                        r_py       <= w_py_new;
                        r_time     <= w_time_new;
                        r_vx       <= r_vx1;
                        r_vy       <= r_vy1;
                        r_ovalid   <= 1'b1;
                        r_o_time   <= w_time_new;
                        r_o_px     <= r_px;
                        r_o_py     <= w_py_new;
                        r_o_vx     <= r_vx;
                        r_o_vy     <= r_vy;
                        r_o_landed <= w_py_new[31];
                        if (w_py_new[31]) begin
                            r_grounded <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.elapsed_time = r_o_time;
    assign o_out.pos_x        = r_o_px;
    assign o_out.pos_y        = r_o_py;
    assign o_out.vel_x        = r_o_vx;
    assign o_out.vel_y        = r_o_vy;
    assign o_out.landed       = r_o_landed;

    `ASSERT_IMPL(a_idle_no_root, r_state == ST_IDLE, !w_sqrt_busy)
    `ASSERT_IMPL(a_root_running, r_state == ST_ROOT, w_sqrt_busy || w_sqrt_done)
    `ASSERT_NEXT(a_step_starts, w_in_acc && i_in.command && !r_grounded, r_state == ST_SQX)
    `ASSERT_NEXT(a_land_grounds, w_fin_go && w_py_new[31], r_grounded && r_ovalid)

endmodule

`default_nettype wire
